FILE: src/rxh_pkg.sv
`timescale 1ns / 1ps

package rxh_pkg;

    localparam int HASH_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int ROT_LEFT    = 4;
    localparam int ROT_RIGHT   = 28;
    localparam int IN_DATA_W   = 24;
    localparam int CNT_W       = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] PRIME_RESET = 32'd4093;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

endpackage

FILE: src/rxh_mix.sv
`timescale 1ns / 1ps

module rxh_mix (
    input  logic [rxh_pkg::BYTE_W-1:0] i_key_byte,
    input  logic [rxh_pkg::LEN_W-1:0]  i_key_length,
    input  logic                       i_first,
    input  logic [rxh_pkg::HASH_W-1:0] i_hash,
    output logic [rxh_pkg::HASH_W-1:0] o_hash
);
    import rxh_pkg::*;

    logic [HASH_W-1:0] w_seed;
    logic [HASH_W-1:0] w_rot;
    logic [HASH_W-1:0] w_byte_ext;

    always_comb begin
        w_seed     = i_first ? {{(HASH_W-LEN_W){1'b0}}, i_key_length} : i_hash;
        w_rot      = {w_seed[HASH_W-ROT_LEFT-1:0], w_seed[HASH_W-1:ROT_RIGHT]};
        // key byte is a signed char
        w_byte_ext = {{(HASH_W-BYTE_W){i_key_byte[BYTE_W-1]}}, i_key_byte};
        o_hash     = w_rot ^ w_byte_ext;
    end

endmodule

FILE: src/rxh_div.sv
`timescale 1ns / 1ps

module rxh_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rxh_pkg::HASH_W-1:0] i_dividend,
    input  logic [rxh_pkg::HASH_W-1:0] i_divisor,
    output logic [rxh_pkg::HASH_W-1:0] o_rem,
    output rxh_pkg::t_div_status       o_status
);
    import rxh_pkg::*;

    logic [HASH_W-1:0] r_rem;
    logic [HASH_W-1:0] r_dvd;
    logic [HASH_W-1:0] r_dsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [HASH_W:0]   w_shift;
    logic [HASH_W:0]   w_diff;
    logic              w_ge;

    // restoring remainder, one dividend bit per cycle
    // a zero divisor always subtracts nothing, so the remainder ends as the dividend
    always_comb begin
        w_shift = {r_rem, r_dvd[HASH_W-1]};
        w_ge    = w_shift >= {1'b0, r_dsr};
        w_diff  = w_shift - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(HASH_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[HASH_W-1:0] : w_shift[HASH_W-1:0];
            r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
        end
    end

    assign o_rem           = r_rem;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

FILE: src/rotate_xor_hash_mod_prime.sv
`timescale 1ns / 1ps
// channel      dir  handshake                      payload
// s_axis       in   s_axis_tvalid / s_axis_tready   tdata key_byte, key_length; tuser first; tlast last
// m_axis       out  m_axis_tvalid / m_axis_tready   tdata bucket
// cfg          in   i_cfg_valid / o_cfg_ready       i_cfg_data bucket_prime
//
// a byte that does not end a key is mixed into the hash as it is taken; a last byte is
// mixed, then run through the bit-serial remainder unit, then loaded into the output register
// synchronous active-low reset: hash cleared, bucket_prime back to 4093
// the finished bucket waits in the output register while new bytes are taken;
// a divide that finishes while that register is still full holds until it drains

module rotate_xor_hash_mod_prime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // key_byte [7:0], key_length [23:8]
    input  logic        s_axis_tuser,   // first_of_key
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // bucket
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import rxh_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] r_prime;
    logic [HASH_W-1:0] r_bucket;
    logic              r_out_valid;

    logic [HASH_W-1:0] w_mixed;
    logic [HASH_W-1:0] w_rem;
    t_div_status       w_div;
    logic              w_in_beat;
    logic              w_out_free;
    logic              w_load;

    rxh_mix u_mix (
        .i_key_byte   (s_axis_tdata[BYTE_W-1:0]),
        .i_key_length (s_axis_tdata[IN_DATA_W-1:BYTE_W]),
        .i_first      (s_axis_tuser),
        .i_hash       (r_hash),
        .o_hash       (w_mixed)
    );

    rxh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_beat && s_axis_tlast),
        .i_dividend (w_mixed),
        .i_divisor  (r_prime),
        .o_rem      (w_rem),
        .o_status   (w_div)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_load        = (r_state == S_DIV) && w_div.done && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_beat && s_axis_tlast) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_prime     <= PRIME_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_beat) r_hash <= w_mixed;
            if (i_cfg_valid) r_prime <= i_cfg_data;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_bucket <= w_rem;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_bucket;

endmodule

FILE: src/rxh_checker.sv
`timescale 1ns / 1ps

module rxh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a waiting bucket beat holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("bucket beat dropped or changed while stalled");

    // a last byte starts the divide, input closes
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after last byte of key");

    // other bytes leave the input open
    a_mid_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("input closed after a middle byte");

    // a new bucket only comes out of a divide
    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("bucket appeared without a divide");

endmodule

bind rotate_xor_hash_mod_prime rxh_checker u_rxh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/tb_rotate_xor_hash_mod_prime.sv
`timescale 1ns / 1ps

module tb_rotate_xor_hash_mod_prime;

    import rxh_pkg::*;

    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_BYTES    = 115;
    localparam int NUM_PHASES     = 9;

    class bucket_scoreboard;
        logic [HASH_W-1:0] running_hash;
        logic [HASH_W-1:0] prime;
        logic [HASH_W-1:0] expected_buckets[$];
        int failures;

        function new();
            running_hash = '0;
            prime = PRIME_RESET;
            failures = 0;
        endfunction

        // one accepted input beat
        function void note_byte(logic [BYTE_W-1:0] key_byte, logic [LEN_W-1:0] key_len,
                                bit first, bit last);
            logic [HASH_W-1:0] byte_ext;
            logic [HASH_W-1:0] h;
            byte_ext = {{(HASH_W-BYTE_W){key_byte[BYTE_W-1]}}, key_byte};
            h = first ? {{(HASH_W-LEN_W){1'b0}}, key_len} : running_hash;
            h = ((h << ROT_LEFT) | (h >> ROT_RIGHT)) ^ byte_ext;
            running_hash = h;
            if (last)
                expected_buckets.push_back((prime == 0) ? h : h % prime);
        endfunction

        function void check_bucket(logic [HASH_W-1:0] actual);
            logic [HASH_W-1:0] want;
            if (expected_buckets.size() == 0) begin
                $display("%0t: unexpected bucket, expected none, actual %h", $time, actual);
                failures++;
                return;
            end
            want = expected_buckets.pop_front();
            if (actual !== want) begin
                $display("%0t: bucket mismatch, expected %h, actual %h", $time, want, actual);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // key_byte [7:0], key_length [23:8]
    logic        s_axis_tuser  = 1'b0; // first_of_key
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // bucket
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data    = '0;

    bucket_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    bit stall_req     = 1'b0;
    int stall_left    = 0;

    rotate_xor_hash_mod_prime dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // bucket sink with random backpressure and a single long hold
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_bucket(m_axis_tdata);
        if (stall_req && stall_left == 0) begin
            stall_left = HOLD_CYCLES;
            stall_req = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(logic [7:0] key_byte, logic [15:0] key_len, bit first, bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tdata  <= {key_len, key_byte};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(key_byte, key_len, first, last);
        bytes_sent++;
    endtask

    task automatic send_key(int n, logic [15:0] key_len, bit with_last);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), key_len, i == 0, with_last && i == n - 1);
    endtask

    task automatic write_prime(logic [31:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.prime = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_buckets.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_traffic(int n_bytes);
        int target;
        int n;
        logic [15:0] key_len;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 8) begin
                // stray beat: random key length and random first and last flags
                send_byte(8'($urandom), 16'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end else begin
                n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                case ($urandom_range(9))
                    0: key_len = 16'($urandom);
                    1: key_len = 16'hFFFF;
                    default: key_len = 16'(n);
                endcase
                send_key(n, key_len, $urandom_range(19) != 0);
            end
        end
    endtask

    task automatic directed_keys();
        // continue from the cleared hash without a seed
        send_byte(8'h5A, 16'h1234, 1'b0, 1'b0);
        send_byte(8'h80, 16'h0000, 1'b0, 1'b1);
        // single-byte keys at the field extremes
        send_byte(8'h80, 16'd1,    1'b1, 1'b1);
        send_byte(8'h7F, 16'hFFFF, 1'b1, 1'b1);
        send_byte(8'hFF, 16'h0000, 1'b1, 1'b1);
        send_byte(8'h00, 16'hAAAA, 1'b1, 1'b1);
        send_byte(8'h01, 16'h5555, 1'b1, 1'b1);
        // well-formed three-byte key
        send_byte(8'h41, 16'd3, 1'b1, 1'b0);
        send_byte(8'h42, 16'd3, 1'b0, 1'b0);
        send_byte(8'h43, 16'd3, 1'b0, 1'b1);
        // continue from the last final hash
        send_byte(8'h01, 16'd0, 1'b0, 1'b1);
        // seed disagrees with the byte count
        send_byte(8'hC3, 16'd5, 1'b1, 1'b0);
        send_byte(8'h3C, 16'd5, 1'b0, 1'b1);
        // long enough for the rotation to wrap
        for (int i = 0; i < 10; i++)
            send_byte(8'h80 + 8'(i * 29), 16'd10, i == 0, i == 9);
    endtask

    initial begin
        logic [31:0] primes[NUM_PHASES];
        primes = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd65521, 32'h7FFF_FFFF,
                   32'd2, $urandom, PRIME_RESET, $urandom_range(3, 300)};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 19;
        recv_idle_pct = 80;
        directed_keys();
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 3)
                0: begin send_idle_pct = 19; recv_idle_pct = 80; end
                1: begin send_idle_pct = 80; recv_idle_pct = 19; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_prime(primes[p]);
            if (p == 6)
                stall_req = 1'b1;
            random_traffic(PHASE_BYTES);
            wait_drained();
        end

        if (sb.failures == 0 && sb.expected_buckets.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
